// ===== hw/rtl/shs_pkg.sv =====
`default_nettype none
package shs_pkg;

  localparam int DATA_W            = 64;
  localparam int IDX_W             = 3;
  localparam int NUM_BUCKETS       = 8;
  localparam int NUM_BOUNDARY_REGS = NUM_BUCKETS - 1;
  localparam int CFG_IDX_W         = 4;

  // Highest number of boundaries honored; larger settings are clamped
  localparam logic [IDX_W-1:0] MAX_BOUNDARIES = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARIES_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_0        = 4'd1;

  // Operation codes carried on s_tuser
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam int S_FIELDS_W = DATA_W + IDX_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 5 * DATA_W + 4 + IDX_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Input tdata, lowest field last
  typedef struct packed {
    logic [S_TDATA_W-S_FIELDS_W-1:0] pad;
    logic [IDX_W-1:0]                bucket_select;
    logic [DATA_W-1:0]               sample_value;
  } sample_in_t;

  // Output tdata, lowest field last
  typedef struct packed {
    logic [M_TDATA_W-M_FIELDS_W-1:0] pad;
    logic [DATA_W-1:0]               bucket_total;
    logic [IDX_W-1:0]                bucket_num;
    logic                            bucket_overflow;
    logic                            sum_overflow;
    logic                            count_overflow;
    logic                            has_samples;
    logic [DATA_W-1:0]               maximum_seen;
    logic [DATA_W-1:0]               minimum_seen;
    logic [DATA_W-1:0]               sample_sum;
    logic [DATA_W-1:0]               sample_count;
  } result_t;

  // Global statistics snapshot taken at the front stage
  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] minv;
    logic [DATA_W-1:0] maxv;
    logic              has;
    logic              cov;
    logic              sov;
  } stats_t;

  // Transaction as it travels down the bucket cells
  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic [DATA_W-1:0] total;
    logic              bkt_sat;
    stats_t            stats;
  } item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/shs_front.sv =====
`default_nettype none
module shs_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [shs_pkg::DATA_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_op,
  input  wire logic [shs_pkg::DATA_W-1:0]     in_sample,
  input  wire logic [shs_pkg::IDX_W-1:0]      in_sel,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output shs_pkg::item_t                      out_item
);

  logic [shs_pkg::IDX_W-1:0]  bnd_in_use;
  logic [shs_pkg::DATA_W-1:0] boundary [shs_pkg::NUM_BOUNDARY_REGS];

  logic [shs_pkg::DATA_W-1:0] count, sum, minv, maxv;
  logic                       cov, sov;
  logic [shs_pkg::DATA_W-1:0] count_next, sum_next, min_next, max_next;
  logic                       cov_next, sov_next;

  logic [shs_pkg::IDX_W-1:0]  used;
  logic [shs_pkg::IDX_W-1:0]  hit_count;
  logic [shs_pkg::DATA_W:0]   sum_wide;
  shs_pkg::item_t             item_next;
  logic                       load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    used = (bnd_in_use > shs_pkg::MAX_BOUNDARIES) ? shs_pkg::MAX_BOUNDARIES : bnd_in_use;
    hit_count = '0;
    for (int i = 0; i < shs_pkg::NUM_BOUNDARY_REGS; i++) begin
      if ((shs_pkg::IDX_W'(i) < used) && (boundary[i] < in_sample)) begin
        hit_count = hit_count + 1'b1;
      end
    end
  end

  always_comb begin
    sum_wide   = {1'b0, sum} + {1'b0, in_sample};
    count_next = count;
    sum_next   = sum;
    min_next   = minv;
    max_next   = maxv;
    cov_next   = cov;
    sov_next   = sov;
    item_next  = '0;
    item_next.op = in_op;
    if (in_op == shs_pkg::OP_RECORD) begin
      if (count == '1) begin
        cov_next = 1'b1;
      end else begin
        count_next = count + 1'b1;
      end
      if (sum_wide[shs_pkg::DATA_W]) begin
        sum_next = '1;
        sov_next = 1'b1;
      end else begin
        sum_next = sum_wide[shs_pkg::DATA_W-1:0];
      end
      if (in_sample < minv) begin
        min_next = in_sample;
      end
      if (in_sample > maxv) begin
        max_next = in_sample;
      end
      item_next.idx      = hit_count;
      item_next.in_range = 1'b1;
    end else begin
      item_next.idx      = in_sel;
      item_next.in_range = (in_sel <= used);
    end
    item_next.stats.count = count_next;
    item_next.stats.sum   = sum_next;
    item_next.stats.has   = (count_next != '0);
    item_next.stats.minv  = item_next.stats.has ? min_next : '0;
    item_next.stats.maxv  = item_next.stats.has ? max_next : '0;
    item_next.stats.cov   = cov_next;
    item_next.stats.sov   = sov_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_in_use <= '0;
      for (int i = 0; i < shs_pkg::NUM_BOUNDARY_REGS; i++) begin
        boundary[i] <= '0;
      end
      count     <= '0;
      sum       <= '0;
      minv      <= '1;
      maxv      <= '0;
      cov       <= 1'b0;
      sov       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == shs_pkg::REG_BOUNDARIES_IN_USE) begin
          bnd_in_use <= cfg_data[shs_pkg::IDX_W-1:0];
        end
        for (int i = 0; i < shs_pkg::NUM_BOUNDARY_REGS; i++) begin
          if (cfg_index == shs_pkg::REG_BOUNDARY_0 + shs_pkg::CFG_IDX_W'(i)) begin
            boundary[i] <= cfg_data;
          end
        end
      end
      if (load) begin
        count <= count_next;
        sum   <= sum_next;
        minv  <= min_next;
        maxv  <= max_next;
        cov   <= cov_next;
        sov   <= sov_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/shs_cell.sv =====
`default_nettype none
module shs_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [shs_pkg::IDX_W-1:0]  cell_id,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire shs_pkg::item_t             in_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output shs_pkg::item_t                  out_item
);

  logic [shs_pkg::DATA_W-1:0] cnt;
  logic [shs_pkg::DATA_W-1:0] cnt_next;
  shs_pkg::item_t             item_next;
  logic                       load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  // Only the cell whose id matches the bucket touches the transaction
  always_comb begin
    cnt_next  = cnt;
    item_next = in_item;
    if (in_item.idx == cell_id) begin
      if (in_item.op == shs_pkg::OP_RECORD) begin
        if (cnt == '1) begin
          item_next.bkt_sat = 1'b1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
        item_next.total = cnt_next;
      end else begin
        item_next.total = in_item.in_range ? cnt : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt <= cnt_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/shs_out.sv =====
`default_nettype none
module shs_out (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire shs_pkg::item_t                 in_item,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [shs_pkg::M_TDATA_W-1:0]       m_tdata
);

  logic             bkt_flag;
  logic             bkt_flag_next;
  shs_pkg::result_t result_next;
  logic             load;

  assign in_ready = !m_tvalid || m_tready;
  assign load     = in_valid && in_ready;

  always_comb begin
    bkt_flag_next               = bkt_flag | in_item.bkt_sat;
    result_next                 = '0;
    result_next.sample_count    = in_item.stats.count;
    result_next.sample_sum      = in_item.stats.sum;
    result_next.minimum_seen    = in_item.stats.minv;
    result_next.maximum_seen    = in_item.stats.maxv;
    result_next.has_samples     = in_item.stats.has;
    result_next.count_overflow  = in_item.stats.cov;
    result_next.sum_overflow    = in_item.stats.sov;
    result_next.bucket_overflow = bkt_flag_next;
    result_next.bucket_num      = in_item.idx;
    result_next.bucket_total    = in_item.total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bkt_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        bkt_flag <= bkt_flag_next;
      end
      if (in_ready) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= result_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/saturating_histogram_stats.sv =====
`default_nettype none
// Histogram statistics over unsigned 64-bit samples. Each transaction on the
// slave side either records a sample (s_tuser low) or reads one bucket counter
// (s_tuser high) and yields exactly one result: saturating sample count and
// sum, minimum and maximum (zero until the first sample), sticky overflow
// flags, and the bucket number with that bucket's count. A front stage computes
// the bucket index with seven parallel boundary compares and updates the global
// statistics; the transaction then walks a row of eight bucket cells, one per
// cycle unless back-pressure holds it, and the cell owning the bucket updates or
// reads its counter as it passes, so back-to-back hits on the same bucket need
// no forwarding. The block takes one transaction per clock cycle while the
// master side is not stalled, through ten register stages (front stage, eight
// cells, output register). Configuration writes are taken in any cycle and
// must happen while idle.
module saturating_histogram_stats (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // sample_value [63:0], bucket_select [66:64], zero pad [71:67]
  input  wire logic [shs_pkg::S_TDATA_W-1:0]  s_tdata,
  // operation [0]
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // sample_count [63:0], sample_sum [127:64], minimum_seen [191:128],
  // maximum_seen [255:192], has_samples [256], count_overflow [257],
  // sum_overflow [258], bucket_overflow [259], bucket number [262:260],
  // bucket_total [326:263], zero pad [327]
  output logic [shs_pkg::M_TDATA_W-1:0]       m_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [shs_pkg::DATA_W-1:0]     cfg_data
);

  shs_pkg::sample_in_t s_fields;
  shs_pkg::result_t    m_result;
  shs_pkg::item_t      chain_item  [shs_pkg::NUM_BUCKETS+1];
  logic                chain_valid [shs_pkg::NUM_BUCKETS+1];
  logic                chain_ready [shs_pkg::NUM_BUCKETS+1];

  assign s_fields  = s_tdata;
  assign m_result  = m_tdata;
  assign cfg_ready = 1'b1;

  shs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_sample (s_fields.sample_value),
    .in_sel    (s_fields.bucket_select),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_item  (chain_item[0])
  );

  for (genvar g = 0; g < shs_pkg::NUM_BUCKETS; g++) begin : g_cell
    shs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (shs_pkg::IDX_W'(g)),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_item   (chain_item[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_item  (chain_item[g+1])
    );
  end

  shs_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[shs_pkg::NUM_BUCKETS]),
    .in_ready (chain_ready[shs_pkg::NUM_BUCKETS]),
    .in_item  (chain_item[shs_pkg::NUM_BUCKETS]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef ASSERT_OFF
  a_front_loaded: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> chain_valid[0])
    else $error("accepted transaction did not reach the front stage");

  a_empty_stats: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_result.has_samples |->
      (m_result.sample_count == '0) && (m_result.minimum_seen == '0) &&
      (m_result.maximum_seen == '0))
    else $error("statistics not zero while no samples recorded");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_result.count_overflow |-> (m_result.sample_count == '1))
    else $error("count overflow flagged below saturation");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_saturating_histogram_stats.sv =====
`timescale 1ns / 1ps
module tb_saturating_histogram_stats;

  localparam int PIPE_LATENCY    = 10;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [shs_pkg::DATA_W-1:0] ALL_ONES = '1;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [shs_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                          s_tuser = shs_pkg::OP_RECORD;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [shs_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [shs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [shs_pkg::DATA_W-1:0]    cfg_data = '0;

  saturating_histogram_stats i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's configuration and statistics
  logic [shs_pkg::IDX_W-1:0]  bounds_used = '0;
  logic [shs_pkg::DATA_W-1:0] bound_q [shs_pkg::NUM_BOUNDARY_REGS];
  logic [shs_pkg::DATA_W-1:0] bucket_q [shs_pkg::NUM_BUCKETS];
  logic [shs_pkg::DATA_W-1:0] hist_count = '0;
  logic [shs_pkg::DATA_W-1:0] hist_sum = '0;
  logic [shs_pkg::DATA_W-1:0] hist_min = '1;
  logic [shs_pkg::DATA_W-1:0] hist_max = '0;
  logic                       count_sat = 1'b0;
  logic                       sum_sat = 1'b0;
  logic                       bkt_sat = 1'b0;

  shs_pkg::result_t predicted_snapshots[$];
  int unsigned      mismatches = 0;
  int unsigned      cycle_count = 0;
  int unsigned      sink_hold_cycles = 0;
  int unsigned      sink_wait = 0;
  bit               src_steady = 1'b0;
  bit               sink_steady = 1'b0;

  initial begin
    for (int i = 0; i < shs_pkg::NUM_BOUNDARY_REGS; i++) bound_q[i] = '0;
    for (int i = 0; i < shs_pkg::NUM_BUCKETS; i++) bucket_q[i] = '0;
  end

  function automatic shs_pkg::result_t histogram_step(logic op,
                                                      logic [shs_pkg::DATA_W-1:0] sample,
                                                      logic [shs_pkg::IDX_W-1:0] sel);
    shs_pkg::result_t           r;
    logic [shs_pkg::IDX_W-1:0]  used;
    logic [shs_pkg::IDX_W-1:0]  idx;
    logic [shs_pkg::DATA_W-1:0] total;
    r = '0;
    used = (bounds_used > shs_pkg::MAX_BOUNDARIES) ? shs_pkg::MAX_BOUNDARIES : bounds_used;
    if (op == shs_pkg::OP_RECORD) begin
      if (hist_count == ALL_ONES) count_sat = 1'b1;
      else hist_count = hist_count + 1'b1;
      if (ALL_ONES - hist_sum < sample) begin
        hist_sum = ALL_ONES;
        sum_sat  = 1'b1;
      end else begin
        hist_sum = hist_sum + sample;
      end
      // one compare per boundary in use, order of boundaries does not matter
      idx = '0;
      for (int i = 0; i < shs_pkg::NUM_BOUNDARY_REGS; i++)
        if (i < used && bound_q[i] < sample) idx = idx + 1'b1;
      if (bucket_q[idx] == ALL_ONES) bkt_sat = 1'b1;
      else bucket_q[idx] = bucket_q[idx] + 1'b1;
      total = bucket_q[idx];
      if (sample < hist_min) hist_min = sample;
      if (sample > hist_max) hist_max = sample;
    end else begin
      idx   = sel;
      total = (idx <= used) ? bucket_q[idx] : '0;
    end
    r.sample_count    = hist_count;
    r.sample_sum      = hist_sum;
    r.has_samples     = (hist_count != 0);
    r.minimum_seen    = r.has_samples ? hist_min : '0;
    r.maximum_seen    = r.has_samples ? hist_max : '0;
    r.count_overflow  = count_sat;
    r.sum_overflow    = sum_sat;
    r.bucket_overflow = bkt_sat;
    r.bucket_num      = idx;
    r.bucket_total    = total;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [shs_pkg::DATA_W-1:0] want,
                             input logic [shs_pkg::DATA_W-1:0] seen);
    if (want !== seen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, actual %h", fname, want, seen);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    shs_pkg::result_t got;
    shs_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (predicted_snapshots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", m_tdata);
      end else begin
        want = predicted_snapshots.pop_front();
        check_field("sample_count", want.sample_count, got.sample_count);
        check_field("sample_sum", want.sample_sum, got.sample_sum);
        check_field("minimum_seen", want.minimum_seen, got.minimum_seen);
        check_field("maximum_seen", want.maximum_seen, got.maximum_seen);
        check_field("has_samples", shs_pkg::DATA_W'(want.has_samples),
                    shs_pkg::DATA_W'(got.has_samples));
        check_field("count_overflow", shs_pkg::DATA_W'(want.count_overflow),
                    shs_pkg::DATA_W'(got.count_overflow));
        check_field("sum_overflow", shs_pkg::DATA_W'(want.sum_overflow),
                    shs_pkg::DATA_W'(got.sum_overflow));
        check_field("bucket_overflow", shs_pkg::DATA_W'(want.bucket_overflow),
                    shs_pkg::DATA_W'(got.bucket_overflow));
        check_field("bucket_num", shs_pkg::DATA_W'(want.bucket_num),
                    shs_pkg::DATA_W'(got.bucket_num));
        check_field("bucket_total", want.bucket_total, got.bucket_total);
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk)
    if (sink_hold_cycles != 0) sink_hold_cycles <= sink_hold_cycles - 1;

  // Receiver: draw a wait after every result transaction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_tvalid && m_tready) sink_wait = sink_steady ? 0 : $urandom_range(0, 14);
      if (sink_hold_cycles != 0) begin
        m_tready <= 1'b0;
      end else if (sink_wait != 0) begin
        m_tready <= 1'b0;
        sink_wait = sink_wait - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic offer_item(input logic op, input logic [shs_pkg::DATA_W-1:0] sample,
                            input logic [shs_pkg::IDX_W-1:0] sel);
    int unsigned         gap;
    shs_pkg::sample_in_t pkt;
    shs_pkg::result_t    snap;
    gap = src_steady ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt = '0;
    pkt.sample_value = sample;
    pkt.bucket_select = sel;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= pkt;
    do @(posedge clk); while (!s_tready);
    snap = histogram_step(op, sample, sel);
    predicted_snapshots.insert(predicted_snapshots.size(), snap);
  endtask

  // Stop offering and let the pipeline empty out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (predicted_snapshots.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [shs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [shs_pkg::DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == shs_pkg::REG_BOUNDARIES_IN_USE)
      bounds_used = data[shs_pkg::IDX_W-1:0];
    else if (idx >= shs_pkg::REG_BOUNDARY_0 &&
             idx < shs_pkg::REG_BOUNDARY_0 + shs_pkg::NUM_BOUNDARY_REGS)
      bound_q[idx - shs_pkg::REG_BOUNDARY_0] = data;
  endtask

  task automatic program_histogram(input logic [shs_pkg::IDX_W-1:0] used,
                                   input logic [shs_pkg::DATA_W-1:0]
                                     bounds [shs_pkg::NUM_BOUNDARY_REGS],
                                   input bit all_spare);
    logic [shs_pkg::DATA_W-1:0]    data;
    logic [shs_pkg::CFG_IDX_W-1:0] spare;
    drain_results();
    data = {$urandom, $urandom};
    data[shs_pkg::IDX_W-1:0] = used;
    write_reg(shs_pkg::REG_BOUNDARIES_IN_USE, data);
    for (int i = 0; i < shs_pkg::NUM_BOUNDARY_REGS; i++)
      write_reg(shs_pkg::REG_BOUNDARY_0 + shs_pkg::CFG_IDX_W'(i), bounds[i]);
    // spare indexes must leave everything untouched
    if (all_spare) begin
      for (int i = shs_pkg::REG_BOUNDARY_0 + shs_pkg::NUM_BOUNDARY_REGS;
           i < (1 << shs_pkg::CFG_IDX_W); i++)
        write_reg(shs_pkg::CFG_IDX_W'(i), {$urandom, $urandom});
    end else begin
      spare = shs_pkg::CFG_IDX_W'($urandom_range(
                shs_pkg::REG_BOUNDARY_0 + shs_pkg::NUM_BOUNDARY_REGS,
                (1 << shs_pkg::CFG_IDX_W) - 1));
      write_reg(spare, {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic make_bounds(output logic [shs_pkg::DATA_W-1:0]
                               bounds [shs_pkg::NUM_BOUNDARY_REGS]);
    logic [shs_pkg::DATA_W-1:0] vals [shs_pkg::NUM_BOUNDARY_REGS];
    int unsigned                style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < shs_pkg::NUM_BOUNDARY_REGS; i++) begin
      case (style)
        1: vals[i] = shs_pkg::DATA_W'($urandom_range(0, 1000));
        3: vals[i] = {32'h0, $urandom};
        default: vals[i] = {$urandom, $urandom};
      endcase
    end
    // style 2 stays unsorted
    if (style != 2) vals.sort();
    for (int i = 0; i < shs_pkg::NUM_BOUNDARY_REGS; i++) bounds[i] = vals[i];
  endtask

  function automatic logic [shs_pkg::DATA_W-1:0] pick_sample();
    logic [shs_pkg::DATA_W-1:0] near;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        near = bound_q[$urandom_range(0, shs_pkg::NUM_BOUNDARY_REGS - 1)];
        return near + shs_pkg::DATA_W'($urandom_range(0, 2)) - 1'b1;
      end
      4, 5, 6: return {$urandom, $urandom};
      7:       return shs_pkg::DATA_W'($urandom_range(0, 255));
      8:       return '0;
      default: return ALL_ONES;
    endcase
  endfunction

  task automatic run_mixed(input int unsigned n_items);
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) < 3)
        offer_item(shs_pkg::OP_READ, {$urandom, $urandom}, shs_pkg::IDX_W'($urandom));
      else
        offer_item(shs_pkg::OP_RECORD, pick_sample(), shs_pkg::IDX_W'($urandom));
    end
  endtask

  // Nothing recorded yet: every bucket reads zero, statistics read zero
  task automatic test_empty_reads();
    for (int i = 0; i < shs_pkg::NUM_BUCKETS; i++)
      offer_item(shs_pkg::OP_READ, '0, shs_pkg::IDX_W'(i));
  endtask

  task automatic test_directed_boundaries();
    logic [shs_pkg::DATA_W-1:0] bounds [shs_pkg::NUM_BOUNDARY_REGS];
    bounds = '{64'd0, 64'd100, 64'd1000, 64'h1_0000_0000, 64'h8000_0000_0000_0000,
               ALL_ONES - 1, ALL_ONES};
    program_histogram(shs_pkg::MAX_BOUNDARIES, bounds, 1'b1);
    offer_item(shs_pkg::OP_RECORD, 64'd0, '0);
    offer_item(shs_pkg::OP_RECORD, 64'd1, '0);
    offer_item(shs_pkg::OP_RECORD, 64'd100, '0);
    offer_item(shs_pkg::OP_RECORD, 64'd101, '0);
    offer_item(shs_pkg::OP_RECORD, 64'd1000, '0);
    offer_item(shs_pkg::OP_RECORD, 64'h1_0000_0001, '0);
    // land the sum on all ones exactly: no overflow yet
    offer_item(shs_pkg::OP_RECORD, ALL_ONES - hist_sum, '0);
    offer_item(shs_pkg::OP_RECORD, 64'd0, '0);
    offer_item(shs_pkg::OP_RECORD, ALL_ONES, '0);
    for (int i = 0; i < shs_pkg::NUM_BUCKETS; i++)
      offer_item(shs_pkg::OP_READ, ALL_ONES, shs_pkg::IDX_W'(i));
  endtask

  task automatic test_random_configs();
    logic [shs_pkg::DATA_W-1:0] bounds [shs_pkg::NUM_BOUNDARY_REGS];
    logic [shs_pkg::IDX_W-1:0]  used;
    for (int p = 0; p < 10; p++) begin
      make_bounds(bounds);
      if (p == 0) used = '0;
      else if (p == 1) used = shs_pkg::MAX_BOUNDARIES;
      else used = shs_pkg::IDX_W'($urandom);
      program_histogram(used, bounds, 1'b0);
      run_mixed(110);
    end
  endtask

  // Receiver stalls long while the sender keeps pushing: input must back up
  task automatic test_output_backpressure();
    drain_results();
    src_steady = 1'b1;
    sink_hold_cycles <= HOLD_OFF_CYCLES;
    for (int k = 0; k < 60; k++) offer_item(shs_pkg::OP_RECORD, pick_sample(), '0);
    src_steady = 1'b0;
  endtask

  task automatic test_steady_stream();
    logic [shs_pkg::DATA_W-1:0] bounds [shs_pkg::NUM_BOUNDARY_REGS];
    make_bounds(bounds);
    program_histogram(shs_pkg::IDX_W'($urandom), bounds, 1'b0);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    for (int k = 0; k < 90; k++) begin
      if (k % 3 == 0)
        offer_item(shs_pkg::OP_READ, {$urandom, $urandom}, shs_pkg::IDX_W'($urandom));
      else
        offer_item(shs_pkg::OP_RECORD, pick_sample(), shs_pkg::IDX_W'($urandom));
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_reads();
    test_directed_boundaries();
    test_random_configs();
    test_output_backpressure();
    test_steady_stream();
    drain_results();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
